### rtl/cnbi_pkg.sv
// ----------------------------------------------------------------------------
// cnbi_pkg
// Shared types, widths and the neighbor step table of the checkerboard
// neighbor index block.
// ----------------------------------------------------------------------------
package cnbi_pkg;

  localparam int SITE_W         = 24;
  localparam int DIR_W          = 2;
  localparam int NB_W           = 3;
  localparam int EXT_W          = 7;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 24;
  localparam int R_W            = SITE_W + 1;
  localparam int CRD_W          = R_W + 1;
  localparam int NEIGHBOURS     = 7;
  localparam int DEF_MAX_EXTENT = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_SIZE,
    CFG_Y_SIZE,
    CFG_Z_SIZE,
    CFG_T_SIZE,
    CFG_HALF_VOLUME
  } cfg_reg_t;

  typedef struct packed {
    logic [DIR_W-1:0] mu;
    logic [DIR_W-1:0] nu;
    logic [NB_W-1:0]  nb;
    logic             bad;
    logic             q0;
    logic             q1;
    logic [EXT_W-1:0] x;
    logic [EXT_W-1:0] y;
  } side_t;

  typedef struct packed {
    logic inc_mu;
    logic dec_mu;
    logic inc_nu;
    logic dec_nu;
  } step_t;

  typedef logic [CRD_W-1:0] coord_t;

  // offset pair (mu,nu) per neighbor number
  function automatic step_t step_of(logic [NB_W-1:0] nb);
    step_t s;
    s = '0;
    case (nb)
      3'd0: s.inc_mu = 1'b1;
      3'd1: s.inc_nu = 1'b1;
      3'd2: begin
        s.dec_mu = 1'b1;
        s.inc_nu = 1'b1;
      end
      3'd3: s.dec_mu = 1'b1;
      3'd4: begin
        s.dec_mu = 1'b1;
        s.dec_nu = 1'b1;
      end
      3'd5: s.dec_nu = 1'b1;
      3'd6: begin
        s.inc_mu = 1'b1;
        s.dec_nu = 1'b1;
      end
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

### rtl/cnbi_in_if.sv
// ----------------------------------------------------------------------------
// cnbi_in_if
// Input channel: one site query per beat.
// ----------------------------------------------------------------------------
interface cnbi_in_if;
  import cnbi_pkg::*;

  logic              valid;
  logic              ready;
  logic [SITE_W-1:0] site;
  logic [DIR_W-1:0]  dir_mu;
  logic [DIR_W-1:0]  dir_nu;
  logic [NB_W-1:0]   neighbour;

  modport source (output valid, site, dir_mu, dir_nu, neighbour, input ready);
  modport sink   (input valid, site, dir_mu, dir_nu, neighbour, output ready);
endinterface

### rtl/cnbi_out_if.sv
// ----------------------------------------------------------------------------
// cnbi_out_if
// Output channel: one neighbor index per beat.
// ----------------------------------------------------------------------------
interface cnbi_out_if;
  import cnbi_pkg::*;

  logic              valid;
  logic              ready;
  logic [SITE_W-1:0] neighbour_site;
  logic              invalid;

  modport source (output valid, neighbour_site, invalid, input ready);
  modport sink   (input valid, neighbour_site, invalid, output ready);
endinterface

### rtl/cnbi_cfg_if.sv
// ----------------------------------------------------------------------------
// cnbi_cfg_if
// Configuration write channel: register index and data per beat.
// ----------------------------------------------------------------------------
interface cnbi_cfg_if;
  import cnbi_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/cnbi_cell.sv
// ----------------------------------------------------------------------------
// cnbi_cell
// One restoring-division cell: resolves one quotient bit and hands the
// partial remainder, shifted dividend/quotient and sideband on.
// ----------------------------------------------------------------------------
module cnbi_cell #(
  parameter int N = 8,
  parameter int M = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [M-1:0]      divisor,
  input  logic              up_valid,
  input  logic [M-1:0]      up_rem,
  input  logic [N-1:0]      up_dq,
  input  cnbi_pkg::side_t   up_side,
  output logic              dn_valid,
  output logic [M-1:0]      dn_rem,
  output logic [N-1:0]      dn_dq,
  output cnbi_pkg::side_t   dn_side
);
  logic [M:0] trial;
  logic       take;

  assign trial = {up_rem, up_dq[N-1]};
  assign take  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_rem  <= take ? M'(trial - {1'b0, divisor}) : trial[M-1:0];
      dn_dq   <= {up_dq[N-2:0], take};
      dn_side <= up_side;
    end
  end
endmodule

### rtl/cnbi_div.sv
// ----------------------------------------------------------------------------
// cnbi_div
// Divider as a chain of N cells, one quotient bit per cell, one beat per
// cycle while adv is high; the whole chain holds while adv is low.
// ----------------------------------------------------------------------------
module cnbi_div #(
  parameter int N = 8,
  parameter int M = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [M-1:0]      divisor,
  input  logic              up_valid,
  input  logic [N-1:0]      up_dq,
  input  cnbi_pkg::side_t   up_side,
  output logic              dn_valid,
  output logic [N-1:0]      dn_quo,
  output logic [M-1:0]      dn_rem,
  output cnbi_pkg::side_t   dn_side
);
  import cnbi_pkg::*;

  logic         v   [N+1];
  logic [M-1:0] rem [N+1];
  logic [N-1:0] dq  [N+1];
  side_t        sd  [N+1];

  assign v[0]   = up_valid;
  assign rem[0] = '0;
  assign dq[0]  = up_dq;
  assign sd[0]  = up_side;

  for (genvar k = 0; k < N; k++) begin : g_cell
    cnbi_cell #(.N(N), .M(M)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .divisor  (divisor),
      .up_valid (v[k]),
      .up_rem   (rem[k]),
      .up_dq    (dq[k]),
      .up_side  (sd[k]),
      .dn_valid (v[k+1]),
      .dn_rem   (rem[k+1]),
      .dn_dq    (dq[k+1]),
      .dn_side  (sd[k+1])
    );
  end

  assign dn_valid = v[N];
  assign dn_quo   = dq[N];
  assign dn_rem   = rem[N];
  assign dn_side  = sd[N];
endmodule

### rtl/cnbi_enc.sv
// ----------------------------------------------------------------------------
// cnbi_enc
// Parity fix-up, periodic shift of mu/nu and even-odd re-encoding,
// five register stages, the last being the output register.
// ----------------------------------------------------------------------------
module cnbi_enc (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              adv,
  input  logic [3:0][cnbi_pkg::EXT_W-1:0]                   ext,
  input  logic [cnbi_pkg::SITE_W-1:0]                       hv,
  input  logic                                              up_valid,
  input  logic [cnbi_pkg::EXT_W-1:0]                        up_z,
  input  logic [cnbi_pkg::R_W-1:0]                          up_t,
  input  cnbi_pkg::side_t                                   up_side,
  output logic                                              dn_valid,
  output logic [cnbi_pkg::SITE_W-1:0]                       dn_site,
  output logic                                              dn_invalid
);
  import cnbi_pkg::*;

  coord_t           cs   [4];
  coord_t           e1_c [4];
  logic             e1_valid, e1_bad;
  logic [R_W-1:0]   e2_w, e3_w, e4_v;
  coord_t           e2_c0, e2_c1, e3_c0;
  logic             e2_valid, e2_bad, e2_par;
  logic             e3_valid, e3_bad, e3_par;
  logic             e4_valid, e4_bad, e4_par;

  always_comb begin
    coord_t c [4];
    coord_t sum;
    coord_t ext_d;
    step_t  st;
    logic   par0, fix, sel_mu, sel_nu, inc, dec;
    c[0] = CRD_W'(up_side.x);
    c[1] = CRD_W'(up_side.y);
    c[2] = CRD_W'(up_z);
    c[3] = CRD_W'(up_t);
    par0 = c[0][0] ^ c[1][0] ^ c[2][0] ^ c[3][0];
    fix  = !((up_side.q0 && !par0) || (up_side.q1 && par0));
    c[0] = c[0] + CRD_W'(fix);
    st   = step_of(up_side.nb);
    for (int d = 0; d < 4; d++) begin
      sel_mu = up_side.mu == DIR_W'(d);
      sel_nu = up_side.nu == DIR_W'(d);
      inc    = (sel_mu && st.inc_mu) || (sel_nu && st.inc_nu);
      dec    = (sel_mu && st.dec_mu) || (sel_nu && st.dec_nu);
      ext_d  = CRD_W'(ext[d]);
      sum    = inc ? c[d] + 1'b1 : (dec ? c[d] - 1'b1 : c[d]);
      if ((sel_mu || sel_nu) && dec && c[d] == '0) begin
        cs[d] = ext_d - 1'b1;
      end else if ((sel_mu || sel_nu) && sum == ext_d) begin
        cs[d] = '0;
      end else begin
        cs[d] = sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
      e2_valid <= 1'b0;
      e3_valid <= 1'b0;
      e4_valid <= 1'b0;
      dn_valid <= 1'b0;
    end else if (adv) begin
      e1_valid <= up_valid;
      e2_valid <= e1_valid;
      e3_valid <= e2_valid;
      e4_valid <= e3_valid;
      dn_valid <= e4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_c   <= cs;
      e1_bad <= up_side.bad;

      e2_w   <= R_W'(e1_c[2]) + R_W'(ext[2]) * R_W'(e1_c[3]);
      e2_c0  <= e1_c[0];
      e2_c1  <= e1_c[1];
      e2_par <= e1_c[0][0] ^ e1_c[1][0] ^ e1_c[2][0] ^ e1_c[3][0];
      e2_bad <= e1_bad;

      e3_w   <= R_W'(e2_c1) + R_W'(ext[1]) * e2_w;
      e3_c0  <= e2_c0;
      e3_par <= e2_par;
      e3_bad <= e2_bad;

      e4_v   <= R_W'(e3_c0) + R_W'(ext[0]) * e3_w;
      e4_par <= e3_par;
      e4_bad <= e3_bad;

      dn_site    <= e4_bad ? '0 : e4_v[R_W-1:1] + (e4_par ? hv : '0);
      dn_invalid <= e4_bad;
    end
  end
endmodule

### rtl/checkerboard_neighbour_index.sv
// ----------------------------------------------------------------------------
// checkerboard_neighbour_index
// Pipeline: 24 divider cells for site/half_volume, 3 x 25 cells for the
// x, y, z decode, 5 re-encode stages. One beat accepted per cycle;
// the whole pipe stalls only while the output register is held.
// Synchronous reset empties the pipe and loads extents 4,4,4,4, half 128.
// ----------------------------------------------------------------------------
module checkerboard_neighbour_index #(
  parameter int MAX_EXTENT = cnbi_pkg::DEF_MAX_EXTENT
) (
  input  logic       clk,
  input  logic       rst,
  cnbi_in_if.sink    in,
  cnbi_out_if.source out,
  cnbi_cfg_if.sink   cfg
);
  import cnbi_pkg::*;

  logic [EXT_W-1:0]      x_size, y_size, z_size, t_size;
  logic [SITE_W-1:0]     half_volume;
  logic [3:0][EXT_W-1:0] ext;
  logic [SITE_W-1:0]     hv;
  logic                  adv;

  logic                  a_valid, b_valid, c_valid, d_valid;
  logic [SITE_W-1:0]     a_quo, a_rem;
  logic [R_W-1:0]        b_quo, c_quo, d_quo;
  logic [EXT_W-1:0]      b_rem, c_rem, d_rem;
  side_t                 side_a, a_side, side_b, b_side, side_c, c_side, side_d, d_side;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_size      <= EXT_W'(4);
      y_size      <= EXT_W'(4);
      z_size      <= EXT_W'(4);
      t_size      <= EXT_W'(4);
      half_volume <= SITE_W'(128);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        CFG_X_SIZE:      x_size      <= cfg.data[EXT_W-1:0];
        CFG_Y_SIZE:      y_size      <= cfg.data[EXT_W-1:0];
        CFG_Z_SIZE:      z_size      <= cfg.data[EXT_W-1:0];
        CFG_T_SIZE:      t_size      <= cfg.data[EXT_W-1:0];
        CFG_HALF_VOLUME: half_volume <= cfg.data[SITE_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    logic [EXT_W-1:0] raw [4];
    raw[0] = x_size;
    raw[1] = y_size;
    raw[2] = z_size;
    raw[3] = t_size;
    for (int d = 0; d < 4; d++) begin
      if (raw[d] == '0) begin
        ext[d] = EXT_W'(1);
      end else if (int'(raw[d]) > MAX_EXTENT) begin
        ext[d] = EXT_W'(MAX_EXTENT);
      end else begin
        ext[d] = raw[d];
      end
    end
  end

  assign hv       = (half_volume == '0) ? SITE_W'(1) : half_volume;
  assign adv      = !out.valid || out.ready;
  assign in.ready = adv;

  always_comb begin
    side_a     = '0;
    side_a.mu  = in.dir_mu;
    side_a.nu  = in.dir_nu;
    side_a.nb  = in.neighbour;
    side_a.bad = (in.dir_mu == in.dir_nu) || (int'(in.neighbour) >= NEIGHBOURS);
  end

  cnbi_div #(.N(SITE_W), .M(SITE_W)) u_div_hv (
    .clk (clk), .rst (rst), .adv (adv), .divisor (hv),
    .up_valid (in.valid), .up_dq (in.site), .up_side (side_a),
    .dn_valid (a_valid), .dn_quo (a_quo), .dn_rem (a_rem), .dn_side (a_side)
  );

  always_comb begin
    side_b    = a_side;
    side_b.q0 = a_quo == '0;
    side_b.q1 = a_quo == SITE_W'(1);
  end

  cnbi_div #(.N(R_W), .M(EXT_W)) u_div_x (
    .clk (clk), .rst (rst), .adv (adv), .divisor (ext[0]),
    .up_valid (a_valid), .up_dq ({a_rem, 1'b0}), .up_side (side_b),
    .dn_valid (b_valid), .dn_quo (b_quo), .dn_rem (b_rem), .dn_side (b_side)
  );

  always_comb begin
    side_c   = b_side;
    side_c.x = b_rem;
  end

  cnbi_div #(.N(R_W), .M(EXT_W)) u_div_y (
    .clk (clk), .rst (rst), .adv (adv), .divisor (ext[1]),
    .up_valid (b_valid), .up_dq (b_quo), .up_side (side_c),
    .dn_valid (c_valid), .dn_quo (c_quo), .dn_rem (c_rem), .dn_side (c_side)
  );

  always_comb begin
    side_d   = c_side;
    side_d.y = c_rem;
  end

  cnbi_div #(.N(R_W), .M(EXT_W)) u_div_z (
    .clk (clk), .rst (rst), .adv (adv), .divisor (ext[2]),
    .up_valid (c_valid), .up_dq (c_quo), .up_side (side_d),
    .dn_valid (d_valid), .dn_quo (d_quo), .dn_rem (d_rem), .dn_side (d_side)
  );

  cnbi_enc u_enc (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .ext        (ext),
    .hv         (hv),
    .up_valid   (d_valid),
    .up_z       (d_rem),
    .up_t       (d_quo),
    .up_side    (d_side),
    .dn_valid   (out.valid),
    .dn_site    (out.neighbour_site),
    .dn_invalid (out.invalid)
  );
endmodule

### tb/sv/tb_checkerboard_neighbour_index.sv
// ----------------------------------------------------------------------------
// tb_checkerboard_neighbour_index
// Self-checking bench for the even-odd lattice neighbor index block. Site
// queries run under several lattice settings: reset, smallest, largest,
// random even-x lattices and inconsistent settings. Each query is predicted
// in the bench. Both channels idle and stall at random, and one long output
// stall backs up the pipe.
// ----------------------------------------------------------------------------
module tb_checkerboard_neighbour_index;
  import cnbi_pkg::*;

  localparam int LATENCY  = 104;
  localparam int WD_LIMIT = 3000;
  localparam int HOLD_LEN = 400;

  typedef struct {
    logic [SITE_W-1:0] site;
    logic              invalid;
  } nbr_result_t;

  logic clk;
  logic rst;

  cnbi_in_if  in_bus ();
  cnbi_out_if out_bus ();
  cnbi_cfg_if cfg_bus ();

  checkerboard_neighbour_index u_dut (
    .clk (clk),
    .rst (rst),
    .in  (in_bus),
    .out (out_bus),
    .cfg (cfg_bus)
  );

  nbr_result_t expected_sites[$];
  int          n_errors;
  int          n_queries;
  int          n_checked;
  int          n_invalid;
  int          n_phases;
  bit          steady_flow;
  bit          hold_req;
  int          idle_cycles;

  logic [EXT_W-1:0]      lat_x, lat_y, lat_z, lat_t;
  logic [CFG_DATA_W-1:0] lat_half;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // even-odd decode, shift by the neighbor's offset pair, re-encode
  function automatic nbr_result_t predict_neighbour(logic [SITE_W-1:0] site,
      logic [DIR_W-1:0] mu, logic [DIR_W-1:0] nu, logic [NB_W-1:0] nb);
    int           off_mu[7] = '{1, 0, -1, -1, -1, 0, 1};
    int           off_nu[7] = '{0, 1, 1, 0, -1, -1, -1};
    longint       ext[4];
    longint       crd[4];
    logic [EXT_W-1:0] raw[4];
    longint       hv, r, v, par;
    nbr_result_t  res;
    res.site = '0;
    res.invalid = 1'b1;
    if (mu == nu || nb >= NEIGHBOURS) return res;
    raw = '{lat_x, lat_y, lat_z, lat_t};
    for (int i = 0; i < 4; i++) begin
      ext[i] = raw[i] == 0 ? 1 : (raw[i] > DEF_MAX_EXTENT ? DEF_MAX_EXTENT : raw[i]);
    end
    hv = lat_half == 0 ? 1 : lat_half;
    r = (longint'(site) % hv) * 2;
    crd[0] = r % ext[0];
    r = r / ext[0];
    crd[1] = r % ext[1];
    r = r / ext[1];
    crd[2] = r % ext[2];
    crd[3] = r / ext[2];
    par = (crd[0] + crd[1] + crd[2] + crd[3]) & 1;
    if (par != longint'(site) / hv) crd[0] += 1;
    crd[mu] += off_mu[nb];
    if (crd[mu] == -1) crd[mu] = ext[mu] - 1;
    else if (crd[mu] == ext[mu]) crd[mu] = 0;
    crd[nu] += off_nu[nb];
    if (crd[nu] == -1) crd[nu] = ext[nu] - 1;
    else if (crd[nu] == ext[nu]) crd[nu] = 0;
    v = crd[3];
    for (int i = 2; i >= 0; i--) v = crd[i] + ext[i] * v;
    par = (crd[0] + crd[1] + crd[2] + crd[3]) & 1;
    res.site = SITE_W'(v / 2 + par * hv);
    res.invalid = 1'b0;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_query(logic [SITE_W-1:0] site, logic [DIR_W-1:0] mu,
      logic [DIR_W-1:0] nu, logic [NB_W-1:0] nb);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.site      <= site;
    in_bus.dir_mu    <= mu;
    in_bus.dir_nu    <= nu;
    in_bus.neighbour <= nb;
    do @(posedge clk); while (!in_bus.ready);
    expected_sites.push_back(predict_neighbour(site, mu, nu, nb));
    n_queries++;
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (expected_sites.size() != 0) @(posedge clk);
    repeat (LATENCY + 16) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_X_SIZE:      lat_x = data[EXT_W-1:0];
      CFG_Y_SIZE:      lat_y = data[EXT_W-1:0];
      CFG_Z_SIZE:      lat_z = data[EXT_W-1:0];
      CFG_T_SIZE:      lat_t = data[EXT_W-1:0];
      CFG_HALF_VOLUME: lat_half = data;
      default: ;
    endcase
  endtask

  task automatic set_lattice(int x, int y, int z, int t, int half);
    drain();
    write_reg(CFG_X_SIZE, CFG_DATA_W'(x));
    write_reg(CFG_Y_SIZE, CFG_DATA_W'(y));
    write_reg(CFG_Z_SIZE, CFG_DATA_W'(z));
    write_reg(CFG_T_SIZE, CFG_DATA_W'(t));
    write_reg(CFG_HALF_VOLUME, CFG_DATA_W'(half));
    cfg_bus.valid <= 1'b0;
    n_phases++;
  endtask

  task automatic send_random(int count, bit any_site);
    logic [SITE_W-1:0] site;
    logic [DIR_W-1:0]  mu, nu;
    logic [NB_W-1:0]   nb;
    longint            span;
    span = 2 * longint'(lat_half == 0 ? 1 : lat_half);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      if (any_site || $urandom_range(0, 9) == 0 || span > (1 << SITE_W))
        site = SITE_W'($urandom);
      else
        site = SITE_W'($urandom_range(0, int'(span - 1)));
      mu = DIR_W'($urandom);
      nu = mu;
      if ($urandom_range(0, 9) != 0) nu = mu + DIR_W'($urandom_range(1, 3));
      nb = ($urandom_range(0, 19) == 0) ? 3'd7 : NB_W'($urandom_range(0, 6));
      send_query(site, mu, nu, nb);
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_reset_lattice();
    send_query(24'd0, 2'd0, 2'd1, 3'd0);
    send_query(24'd255, 2'd3, 2'd2, 3'd1);
    send_query(24'd127, 2'd1, 2'd0, 3'd2);
    send_query(24'd128, 2'd2, 2'd3, 3'd3);
    send_query(24'hFFFFFF, 2'd0, 2'd3, 3'd4);
    send_query(24'h800000, 2'd3, 2'd0, 3'd5);
    send_query(24'd200, 2'd1, 2'd2, 3'd6);
    send_query(24'd17, 2'd2, 2'd2, 3'd0);
    send_query(24'd17, 2'd0, 2'd1, 3'd7);
    send_query(24'd64, 2'd3, 2'd3, 3'd7);
    for (int m = 0; m < 4; m++) begin
      send_query(SITE_W'(m * 37 + 5), DIR_W'(m), DIR_W'(m + 1), NB_W'(m));
      send_query(SITE_W'(m * 53 + 90), DIR_W'(m), DIR_W'(m + 2), NB_W'(m + 3));
    end
  endtask

  task automatic test_extreme_lattices();
    set_lattice(2, 1, 1, 1, 1);
    send_random(30, 1'b0);
    set_lattice(64, 64, 64, 64, 8388608);
    send_random(40, 1'b0);
    send_random(20, 1'b1);
  endtask

  task automatic test_random_lattices();
    int x, y, z, t;
    for (int p = 0; p < 4; p++) begin
      x = 2 * $urandom_range(1, 32);
      y = $urandom_range(1, 64);
      z = $urandom_range(1, 16);
      t = $urandom_range(1, 64);
      set_lattice(x, y, z, t, x * y * z * t / 2);
      send_random(70, 1'b0);
    end
  endtask

  task automatic test_odd_settings();
    set_lattice(5, 3, 7, 2, 52);
    send_random(40, 1'b0);
    set_lattice(0, 127, 100, 0, 0);
    send_random(40, 1'b1);
    set_lattice(127, 65, 0, 9, $urandom);
    send_random(40, 1'b1);
    set_lattice($urandom_range(0, 127), $urandom_range(0, 127),
                $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
    send_random(40, 1'b1);
  endtask

  task automatic test_backpressure();
    set_lattice(8, 6, 4, 10, 960);
    hold_req = 1'b1;
    steady_flow = 1'b1;
    send_random(170, 1'b0);
  endtask

  // output side: random stalls, plus one long hold when requested
  initial begin
    int len;
    out_bus.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        len = $urandom_range(0, 99);
        if (len < 80) begin
          out_bus.ready <= 1'b1;
          repeat ($urandom_range(1, 30)) @(posedge clk);
        end else begin
          out_bus.ready <= 1'b0;
          repeat (len < 96 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    nbr_result_t exp_res;
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (expected_sites.size() == 0) begin
        $error("unexpected beat: neighbour_site %0d invalid %0b",
               out_bus.neighbour_site, out_bus.invalid);
        n_errors++;
      end else begin
        exp_res = expected_sites.pop_front();
        n_checked++;
        if (exp_res.invalid) n_invalid++;
        if (out_bus.neighbour_site !== exp_res.site) begin
          $error("neighbour_site: expected %0d actual %0d", exp_res.site,
                 out_bus.neighbour_site);
          n_errors++;
        end
        if (out_bus.invalid !== exp_res.invalid) begin
          $error("invalid: expected %0b actual %0b", exp_res.invalid, out_bus.invalid);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WD_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    n_errors = 0;
    n_queries = 0;
    n_checked = 0;
    n_invalid = 0;
    n_phases = 1;
    steady_flow = 1'b0;
    hold_req = 1'b0;
    lat_x = 4;
    lat_y = 4;
    lat_z = 4;
    lat_t = 4;
    lat_half = 128;
    rst <= 1'b1;
    in_bus.valid <= 1'b0;
    in_bus.site <= '0;
    in_bus.dir_mu <= '0;
    in_bus.dir_nu <= '0;
    in_bus.neighbour <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_X_SIZE;
    cfg_bus.data <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_lattice();
    test_extreme_lattices();
    test_random_lattices();
    test_odd_settings();
    test_backpressure();
    drain();
    $display("covered %0d queries over %0d lattice settings, %0d flagged invalid",
             n_queries, n_phases, n_invalid);
    $display("%0d results checked, long output stall included", n_checked);
    if (n_errors == 0 && expected_sites.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
